// ----- rtl/hgb_pkg.sv -----
// Shared types and constants of the horizontal Gaussian blur core.
// Used by every module of the core; depends on nothing.
package hgb_pkg;

    localparam int PIXEL_W      = 8;
    localparam int COUNT_W      = 5;   // row pixel count, also holds the radius
    localparam int COUNT_MAX    = 31;
    localparam int RADIUS_W     = 4;
    localparam int RADIUS_RESET = 10;
    localparam int WFIELD_W     = 16;  // one weight inside a weight word
    localparam int WWORD_W      = 64;
    localparam int NUM_WWORDS   = 4;
    localparam int MAX_WEIGHTS  = 16;
    localparam int CFG_INDEX_W  = 3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_RADIUS  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT0 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT1 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT2 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT3 = 3'd4;

    // Command passed from the front end to the back end
    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               fill;      // first pixel of a row: fill the window
        logic               row_end;   // last pixel of a row: flush follows for a nonzero radius
        logic [COUNT_W-1:0] count;     // pixels already seen in this row
    } cmd_t;

    // Flags of one output job travelling down the arithmetic pipeline
    typedef struct packed {
        logic valid;
        logic row_last;
        logic last_of_run;
    } job_t;

endpackage

// ----- rtl/hgb_front.sv -----
// Front end of the blur core: accepts pixel beats and classifies them.
// Depends on hgb_pkg.
module hgb_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [hgb_pkg::PIXEL_W-1:0]   pixel,
    input  logic                          row_end,
    input  logic                          fifo_full,
    output logic                          push,
    output hgb_pkg::cmd_t                 cmd
);

    logic [hgb_pkg::COUNT_W-1:0] count_reg;
    logic [hgb_pkg::COUNT_W-1:0] count_next;

    assign in_ready = !fifo_full;
    assign push     = in_valid && !fifo_full;

    always_comb
    begin
        cmd.pixel   = pixel;
        cmd.fill    = (count_reg == '0);
        cmd.row_end = row_end;
        cmd.count   = count_reg;
        count_next  = count_reg;
        if (push)
        begin
            if (row_end)
                count_next = '0;
            else if (count_reg != hgb_pkg::COUNT_W'(hgb_pkg::COUNT_MAX))
                count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

// ----- rtl/hgb_cmd_fifo.sv -----
// Short command queue between the front and back ends of the blur core.
// Depends on hgb_pkg.
module hgb_cmd_fifo
#(
    parameter int DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hgb_pkg::cmd_t wr_cmd,
    output logic          full,
    input  logic          pop,
    output logic          rd_valid,
    output hgb_pkg::cmd_t rd_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hgb_pkg::cmd_t  mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;

    assign full     = (count_reg == CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ----- rtl/hgb_back.sv -----
// Back end sequencer of the blur core: keeps the pixel window, expands a row
// end into its flush steps and issues one job per output. Depends on hgb_pkg.
module hgb_back
#(
    parameter int MAX_RADIUS = 15
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic [hgb_pkg::COUNT_W-1:0]  radius,
    input  logic                         q_valid,
    input  hgb_pkg::cmd_t                q_cmd,
    output logic                         pop,
    output logic [hgb_pkg::PIXEL_W-1:0]  win [2*MAX_RADIUS+1],
    output hgb_pkg::job_t                job
);

    localparam int WIN = 2 * MAX_RADIUS + 1;

    logic [hgb_pkg::PIXEL_W-1:0] win_reg [WIN];
    hgb_pkg::job_t               job_reg;
    logic                        flush_reg;
    logic [hgb_pkg::COUNT_W-1:0] k_reg;
    logic [hgb_pkg::PIXEL_W-1:0] pix_reg;
    logic [hgb_pkg::COUNT_W-1:0] v_reg;

    logic                        step;
    logic                        fill;
    logic                        endf;
    logic [hgb_pkg::PIXEL_W-1:0] p;
    logic [hgb_pkg::COUNT_W-1:0] k;
    logic [hgb_pkg::COUNT_W-1:0] v;
    logic [hgb_pkg::COUNT_W-1:0] extra;
    logic                        emit;
    logic                        last;

    assign win = win_reg;
    assign job = job_reg;

    always_comb
    begin
        pop  = adv && !flush_reg && q_valid;
        step = adv && (flush_reg || q_valid);
        if (flush_reg)
        begin
            k    = k_reg;
            v    = v_reg;
            p    = pix_reg;
            endf = 1'b1;
            fill = 1'b0;
        end
        else
        begin
            k    = '0;
            v    = q_cmd.count;
            p    = q_cmd.pixel;
            endf = q_cmd.row_end;
            fill = q_cmd.fill;
        end
        extra = endf ? radius : '0;
        // An output is due once the centre has reached a pixel of the row.
        emit  = ({1'b0, v} + {1'b0, k}) >= {1'b0, radius};
        last  = (k == extra);
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            if (fill)
            begin
                for (int i = 0; i < WIN; i++)
                    win_reg[i] <= p;
            end
            else
            begin
                for (int i = 0; i < WIN - 1; i++)
                    win_reg[i] <= win_reg[i+1];
                win_reg[WIN-1] <= p;
            end
        end
        if (pop)
        begin
            pix_reg <= q_cmd.pixel;
            v_reg   <= q_cmd.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_reg   <= '0;
            flush_reg <= 1'b0;
            k_reg     <= '0;
        end
        else if (adv)
        begin
            job_reg.valid       <= step && emit;
            job_reg.row_last    <= endf && last;
            job_reg.last_of_run <= last;
            if (flush_reg)
            begin
                flush_reg <= !last;
                k_reg     <= k_reg + 1'b1;
            end
            else if (pop && (extra != '0))
            begin
                flush_reg <= 1'b1;
                k_reg     <= hgb_pkg::COUNT_W'(1);
            end
        end
    end

endmodule

// ----- rtl/hgb_mac.sv -----
// Arithmetic pipeline of the blur core: tap pairing, weight products, adder
// tree, truncation and saturation, and the output register. Depends on hgb_pkg.
module hgb_mac
#(
    parameter int MAX_RADIUS  = 15,
    parameter int WEIGHT_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    output logic                         adv,
    input  logic [hgb_pkg::COUNT_W-1:0]  radius,
    input  logic [hgb_pkg::WWORD_W-1:0]  wword [hgb_pkg::NUM_WWORDS],
    input  logic [hgb_pkg::PIXEL_W-1:0]  win [2*MAX_RADIUS+1],
    input  hgb_pkg::job_t                job,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [hgb_pkg::PIXEL_W-1:0]  out_pixel,
    output logic                         out_row_last,
    output logic                         out_last_of_run
);

    localparam int WIN   = 2 * MAX_RADIUS + 1;
    localparam int TOP   = WIN - 1;
    localparam int IW    = $clog2(WIN);
    localparam int NLANE = ((MAX_RADIUS < hgb_pkg::MAX_WEIGHTS - 1) ?
                            MAX_RADIUS : hgb_pkg::MAX_WEIGHTS - 1) + 1;
    localparam int NGRP  = (NLANE + 3) / 4;
    localparam int SW    = hgb_pkg::PIXEL_W + 1;
    localparam int PW    = SW + hgb_pkg::WFIELD_W;
    localparam int GW    = PW + 2;
    localparam int TW    = (WEIGHT_BITS + 9 > GW + 2) ? WEIGHT_BITS + 9 : GW + 2;

    hgb_pkg::job_t s1_reg, s2_reg, s3_reg, s4_reg;
    logic [SW-1:0] pair_reg [NLANE];
    logic [PW-1:0] prod_reg [NLANE];
    logic [GW-1:0] grp_reg  [NGRP];
    logic [TW-1:0] total_reg;
    logic          out_valid_reg;
    logic [hgb_pkg::PIXEL_W-1:0] out_pixel_reg;
    logic          out_row_last_reg;
    logic          out_last_reg;

    logic [SW-1:0] pair_next [NLANE];
    logic [hgb_pkg::WFIELD_W-1:0] weight [NLANE];
    logic [GW-1:0] grp_next  [NGRP];
    logic [TW-1:0] total_next;
    logic [TW-1:0] shifted;
    logic [IW-1:0] idx_lo;
    logic [IW-1:0] idx_hi;

    assign adv             = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_pixel       = out_pixel_reg;
    assign out_row_last    = out_row_last_reg;
    assign out_last_of_run = out_last_reg;

    // Pair the two taps at equal distance from the centre; lane 0 is the centre.
    always_comb
    begin
        idx_lo = '0;
        idx_hi = '0;
        for (int d = 0; d < NLANE; d++)
        begin
            weight[d]    = wword[d / 4][hgb_pkg::WFIELD_W * (d % 4) +: hgb_pkg::WFIELD_W];
            pair_next[d] = '0;
            if (d <= int'(radius))
            begin
                idx_lo = IW'(TOP - int'(radius) - d);
                idx_hi = IW'(TOP - int'(radius) + d);
                if (d == 0)
                    pair_next[d] = SW'(win[idx_lo]);
                else
                    pair_next[d] = SW'(win[idx_lo]) + SW'(win[idx_hi]);
            end
        end
    end

    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = '0;
            for (int j = 0; j < 4; j++)
            begin
                if (4 * g + j < NLANE)
                    grp_next[g] = grp_next[g] + GW'(prod_reg[4*g+j]);
            end
        end
        total_next = '0;
        for (int g = 0; g < NGRP; g++)
            total_next = total_next + TW'(grp_reg[g]);
        shifted = total_reg >> WEIGHT_BITS;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int d = 0; d < NLANE; d++)
            begin
                pair_reg[d] <= pair_next[d];
                prod_reg[d] <= PW'(pair_reg[d] * weight[d]);
            end
            for (int g = 0; g < NGRP; g++)
                grp_reg[g] <= grp_next[g];
            total_reg <= total_next;
            out_pixel_reg <= (shifted > TW'(255)) ? 8'hFF : shifted[hgb_pkg::PIXEL_W-1:0];
            out_row_last_reg <= s4_reg.row_last;
            out_last_reg     <= s4_reg.last_of_run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg        <= '0;
            s2_reg        <= '0;
            s3_reg        <= '0;
            s4_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_reg        <= job;
            s2_reg        <= s1_reg;
            s3_reg        <= s2_reg;
            s4_reg        <= s3_reg;
            out_valid_reg <= s4_reg.valid;
        end
    end

endmodule

// ----- rtl/horizontal_gaussian_blur_core.sv -----
// Top level of the horizontal Gaussian blur core: configuration registers,
// front end, command queue, back end and arithmetic pipeline. Depends on hgb_pkg.
//
// The core blurs 8-bit grey pixels along each row. Pixels arrive one per beat in
// raster order with tlast on the last pixel of a row, and every output beat is the
// weighted sum of the 2R+1 pixels around its centre (R = radius register, limited
// to MAX_RADIUS), truncated by WEIGHT_BITS and saturated at 255. Pixels beyond
// either end of a row take the value of the first or last pixel. Outputs lag the
// input by R pixels; a row end releases the outputs still owed for its row as a
// burst of up to R+1 beats (R+1 for rows of at least R+1 pixels), the last one
// carrying tlast, and tuser marks the final beat caused by each input beat.
// Weights are loaded by software as normalised Q0.16 values, four per 64-bit
// weight word. In steady state the core takes one pixel per clock cycle while the
// output is not stalled: the back end sequencer performs one window step per cycle,
// so a row end occupies it while its flush steps run, which the four-entry command
// queue partly absorbs before the input is held. An accepted input beat passes the
// command queue, then the window step, pairing, product, two adder levels and the
// output register before its first output is offered. Configuration must only be
// written while the core is idle.
module horizontal_gaussian_blur_core
#(
    parameter int MAX_RADIUS  = 15,
    parameter int WEIGHT_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_in
    input  logic        s_axis_tlast,   // row_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] blurred_pixel
    output logic        m_axis_tlast,   // row_last
    output logic        m_axis_tuser,   // [0] last_of_run
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int WIN = 2 * MAX_RADIUS + 1;

    logic [hgb_pkg::RADIUS_W-1:0] radius_reg;
    logic [hgb_pkg::WWORD_W-1:0]  wword_reg [hgb_pkg::NUM_WWORDS];
    logic [hgb_pkg::COUNT_W-1:0]  radius_eff;

    logic                         push;
    logic                         fifo_full;
    hgb_pkg::cmd_t                wr_cmd;
    logic                         pop;
    logic                         q_valid;
    hgb_pkg::cmd_t                q_cmd;
    logic                         adv;
    logic [hgb_pkg::PIXEL_W-1:0]  win [WIN];
    hgb_pkg::job_t                job;

    // Configuration registers; writes beyond the last weight word are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= hgb_pkg::RADIUS_W'(hgb_pkg::RADIUS_RESET);
            for (int i = 0; i < hgb_pkg::NUM_WWORDS; i++)
                wword_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hgb_pkg::CFG_RADIUS:  radius_reg   <= cfg_data[hgb_pkg::RADIUS_W-1:0];
                hgb_pkg::CFG_WEIGHT0: wword_reg[0] <= cfg_data;
                hgb_pkg::CFG_WEIGHT1: wword_reg[1] <= cfg_data;
                hgb_pkg::CFG_WEIGHT2: wword_reg[2] <= cfg_data;
                hgb_pkg::CFG_WEIGHT3: wword_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // A radius above the window capacity is treated as the largest one.
    assign radius_eff = (hgb_pkg::COUNT_W'(radius_reg) > hgb_pkg::COUNT_W'(MAX_RADIUS)) ?
                        hgb_pkg::COUNT_W'(MAX_RADIUS) : hgb_pkg::COUNT_W'(radius_reg);

    hgb_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .pixel     (s_axis_tdata),
        .row_end   (s_axis_tlast),
        .fifo_full (fifo_full),
        .push      (push),
        .cmd       (wr_cmd)
    );

    hgb_cmd_fifo #(.DEPTH(4)) u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_cmd   (wr_cmd),
        .full     (fifo_full),
        .pop      (pop),
        .rd_valid (q_valid),
        .rd_cmd   (q_cmd)
    );

    hgb_back #(.MAX_RADIUS(MAX_RADIUS)) u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .radius  (radius_eff),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .pop     (pop),
        .win     (win),
        .job     (job)
    );

    hgb_mac #(.MAX_RADIUS(MAX_RADIUS), .WEIGHT_BITS(WEIGHT_BITS)) u_mac
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .adv             (adv),
        .radius          (radius_eff),
        .wword           (wword_reg),
        .win             (win),
        .job             (job),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_pixel       (m_axis_tdata),
        .out_row_last    (m_axis_tlast),
        .out_last_of_run (m_axis_tuser)
    );

endmodule

// ----- rtl/hgb_checker.sv -----
// Port-level checks of the horizontal Gaussian blur core, bound to its top level.
// Depends only on the ports of horizontal_gaussian_blur_core.
module hgb_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic       m_axis_tuser
);

    // A stalled output beat stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat withdrawn while stalled");

    // A stalled output beat keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("output payload changed while stalled");

    // The last pixel of a row is always the final beat of its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
        else $error("row end beat not marked as end of run");

    // Nothing leaves the pipeline straight after reset.
    assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("output beat right after reset");

endmodule

bind horizontal_gaussian_blur_core hgb_checker u_hgb_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- bench/tb_horizontal_gaussian_blur_core.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the horizontal Gaussian blur core: streams rows of
// pixels, predicts every output beat in a scoreboard and compares. Depends on hgb_pkg.
module tb_horizontal_gaussian_blur_core;

    typedef struct packed {
        logic [7:0] pixel;
        logic       row_end;
    } pix_beat_t;

    typedef struct packed {
        logic [7:0] blurred;
        logic       row_last;
        logic       run_last;
    } blur_beat_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    horizontal_gaussian_blur_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Bench copy of the block's state and configuration.
    logic [3:0]  radius_reg;
    logic [63:0] weight_words [hgb_pkg::NUM_WWORDS];
    logic [7:0]  window [31];
    int unsigned pixels_in_row;

    pix_beat_t  pending_pixels [$];
    blur_beat_t expected_blur [$];
    int unsigned error_count;
    int unsigned hold_off_cycles;   // receiver hold-off requested by the stimulus
    bit          pause_sender;
    bit          in_taken;          // input beat accepted at the last rising edge
    bit          hold_done;
    bit          pause_done;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [15:0] weight_at(int unsigned offset);
        if (offset > 15)
            return 16'd0;
        return weight_words[offset >> 2][16 * (offset & 3) +: 16];
    endfunction

    // Weighted sum around the window centre R places below the newest pixel.
    function automatic logic [7:0] blur_window(int unsigned r);
        logic [63:0] acc;
        int unsigned centre;
        centre = 30 - r;
        acc = 64'(window[centre]) * weight_at(0);
        for (int unsigned d = 1; d <= r; d++)
            acc += (64'(window[centre - d]) + window[centre + d]) * weight_at(d);
        acc = acc >> 16;
        return (acc > 255) ? 8'd255 : acc[7:0];
    endfunction

    function automatic void push_window(logic [7:0] p);
        for (int i = 0; i < 30; i++)
            window[i] = window[i + 1];
        window[30] = p;
    endfunction

    // Predict the output beats caused by one accepted pixel beat.
    function automatic void predict_blur(pix_beat_t b);
        int unsigned r, seen, extra;
        blur_beat_t o;
        r = (radius_reg > 15) ? 15 : radius_reg;
        seen = pixels_in_row;
        extra = b.row_end ? r : 0;
        if (pixels_in_row == 0)
            for (int i = 0; i < 31; i++)
                window[i] = b.pixel;
        else
            push_window(b.pixel);
        for (int unsigned k = 0; k <= extra; k++)
        begin
            if (k > 0)
                push_window(b.pixel);
            if (seen + k >= r)
            begin
                o.blurred  = blur_window(r);
                o.row_last = b.row_end && (k == extra);
                o.run_last = (k == extra);
                expected_blur.push_back(o);
            end
        end
        if (b.row_end)
            pixels_in_row = 0;
        else if (pixels_in_row < 31)
            pixels_in_row++;
    endfunction

    // The input handshake is taken at the rising edge, where it happens.
    always @(posedge clk)
    begin
        in_taken <= rst_n && s_axis_tvalid && s_axis_tready;
    end

    // Driver: offers queued pixels with random gaps, changing inputs on the falling edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
            begin
                predict_blur(pending_pixels.pop_front());
            end
            if ((!s_axis_tvalid || in_taken))
            begin
                if (pending_pixels.size() > 0 && !pause_sender
                    && ($urandom_range(0, 3) != 0 || hold_off_cycles > 0))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_pixels[0].pixel;
                    s_axis_tlast  <= pending_pixels[0].row_end;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure: random short stalls, a few long ones, and a hold-off.
    int unsigned stall_left;
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_axis_tready   <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if ($urandom_range(0, 9) < 2)
        begin
            stall_left    <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: compares every accepted output beat with the oldest prediction.
    always @(posedge clk)
    begin
        blur_beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_blur.size() == 0)
            begin
                $display("%0t: unexpected beat: expected none, actual %h/%b/%b",
                         $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
                error_count++;
            end
            else
            begin
                want = expected_blur.pop_front();
                if (want.blurred !== m_axis_tdata)
                begin
                    $display("%0t: pixel mismatch: expected %0d, actual %0d",
                             $time, want.blurred, m_axis_tdata);
                    error_count++;
                end
                if (want.row_last !== m_axis_tlast)
                begin
                    $display("%0t: tlast mismatch: expected %b, actual %b",
                             $time, want.row_last, m_axis_tlast);
                    error_count++;
                end
                if (want.run_last !== m_axis_tuser)
                begin
                    $display("%0t: tuser mismatch: expected %b, actual %b",
                             $time, want.run_last, m_axis_tuser);
                    error_count++;
                end
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == hgb_pkg::CFG_RADIUS)
            radius_reg = value[3:0];
        else if (idx <= hgb_pkg::CFG_WEIGHT3)
            weight_words[idx - 1] = value;
    endtask

    // Wait until every queued pixel is taken and every prediction has come back,
    // then let the pipeline drain before touching the registers.
    task automatic wait_idle();
        while (pending_pixels.size() > 0 || expected_blur.size() > 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // Load zero weights, all-ones weights for the saturating cases, random words, or a rough bell shape.
    task automatic load_weights(int unsigned shape);
        logic [63:0] w;
        for (int k = 0; k < hgb_pkg::NUM_WWORDS; k++)
        begin
            case (shape)
                0: w = 64'h0;
                1: w = {4{16'hFFFF}};
                2: w = {$urandom, $urandom};
                default: w = {16'(4096 >> (4*k+3)), 16'(4096 >> (4*k+2)),
                              16'(4096 >> (4*k+1)), 16'(8192 >> (4*k))};
            endcase
            write_reg(3'(hgb_pkg::CFG_WEIGHT0 + k), w);
        end
    endtask

    task automatic queue_row(int unsigned len, int unsigned mode);
        pix_beat_t b;
        for (int unsigned i = 0; i < len; i++)
        begin
            case (mode)
                0: b.pixel = 8'd255;
                1: b.pixel = 8'd0;
                default: b.pixel = $urandom_range(0, 255);
            endcase
            b.row_end = (i == len - 1);
            pending_pixels.push_back(b);
        end
    endtask

    initial
    begin
        int unsigned issued;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        hold_off_cycles = 0;
        pause_sender = 1'b0;
        hold_done = 1'b0;
        pause_done = 1'b0;
        stall_left = 0;
        pixels_in_row = 0;
        radius_reg = hgb_pkg::RADIUS_RESET;
        for (int k = 0; k < hgb_pkg::NUM_WWORDS; k++)
            weight_words[k] = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: zero weights at the reset radius, then saturating weights with extreme
        // pixels and a single-pixel row, then bell weights on short rows at radius 15 and 0.
        queue_row(3, 0);
        wait_idle();
        load_weights(1);
        queue_row(12, 0);
        queue_row(1, 1);
        wait_idle();
        write_reg(hgb_pkg::CFG_RADIUS, 64'd15);
        load_weights(3);
        queue_row(4, 2);
        wait_idle();
        write_reg(hgb_pkg::CFG_RADIUS, 64'd0);
        queue_row(2, 2);
        wait_idle();
        // An out-of-range index must be ignored by the core.
        write_reg(3'd7, {$urandom, $urandom});

        // Random phases; each phase picks a radius and a weight set.
        issued = 0;
        while (issued < 120)
        begin
            int unsigned len;
            write_reg(hgb_pkg::CFG_RADIUS, 64'($urandom_range(0, 15)));
            load_weights($urandom_range(1, 3));
            for (int r = 0; r < 3; r++)
            begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5)
                                                  : $urandom_range(6, 24);
                queue_row(len, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : 2);
                issued += len;
            end
            if (!hold_done && issued > 30)
            begin
                hold_off_cycles = 60;    // long receiver hold-off to fill the core
                hold_done = 1'b1;
            end
            else if (hold_done && !pause_done)
            begin
                // Sender pauses until everything so far has come back.
                while (pending_pixels.size() > 0)
                    @(negedge clk);
                pause_sender = 1'b1;
                while (expected_blur.size() > 0)
                    @(negedge clk);
                pause_sender = 1'b0;
                pause_done = 1'b1;
            end
            wait_idle();
        end

        wait_idle();
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
